[rtl/csvrs_pkg.sv]
// ----------------------------------------------------------------------------
// csvrs_pkg
// Shared types and constants for the CSV row splitter with type inference.
// ----------------------------------------------------------------------------
package csvrs_pkg;

   localparam int MAX_COLUMNS_DEF = 32;

   localparam int BYTE_W = 8;
   localparam int COL_W  = 6;
   localparam int MASK_W = 32;
   localparam int ROWS_W = 16;
   localparam int STAT_W = 2;
   localparam int RSP_W  = STAT_W + COL_W + MASK_W + ROWS_W;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [MASK_W-1:0] mask_type;
   typedef logic [ROWS_W-1:0] rows_type;

   typedef enum logic [STAT_W-1:0] {
      ST_ACCEPT   = 2'd0,
      ST_MISMATCH = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_END      = 2'd3
   } status_type;

   // Character codes
   localparam byte_type CH_TAB    = 8'h09;
   localparam byte_type CH_LF     = 8'h0a;
   localparam byte_type CH_CR     = 8'h0d;
   localparam byte_type CH_SPACE  = 8'h20;
   localparam byte_type CH_QUOTE  = 8'h22;
   localparam byte_type CH_COMMA  = 8'h2c;
   localparam byte_type CH_MINUS  = 8'h2d;
   localparam byte_type CH_PERIOD = 8'h2e;
   localparam byte_type CH_ZERO   = 8'h30;
   localparam byte_type CH_NINE   = 8'h39;

   typedef struct packed {
      status_type status;
      col_type    field_count;
      mask_type   column_string_mask;
      rows_type   rows_accepted;
   } rsp_type;

   typedef struct packed {
      logic res_valid;   // a row closed on this step
      logic halted;      // state before this step
   } core_stat_type;

endpackage

[rtl/csvrs_core.sv]
// ----------------------------------------------------------------------------
// csvrs_core
// Per-byte tokenizer and field classifier; closes rows and builds the result.
// ----------------------------------------------------------------------------
module csvrs_core #(
   parameter int MAX_COLUMNS = csvrs_pkg::MAX_COLUMNS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  csvrs_pkg::byte_type      char_byte,
   input  logic                     end_of_stream,
   input  csvrs_pkg::col_type       expected_columns,
   output csvrs_pkg::core_stat_type stat,
   output csvrs_pkg::rsp_type       res
);

   localparam int CW   = $clog2(MAX_COLUMNS + 3);
   localparam int CMPW = (CW > csvrs_pkg::COL_W) ? CW : csvrs_pkg::COL_W;

   typedef logic [CW-1:0]   cnt_type;
   typedef logic [CMPW-1:0] cmp_type;

   csvrs_pkg::mask_type col_mask_ff, col_mask_in;
   csvrs_pkg::mask_type row_mask_ff, row_mask_in;
   csvrs_pkg::rows_type rows_ff, rows_in;
   cnt_type             idx_ff, idx_in;
   logic in_q_ff, in_q_in;
   logic started_ff, started_in;
   logic opened_ff, opened_in;
   logic hquote_ff, hquote_in;
   logic hspace_ff, hspace_in;
   logic period_ff, period_in;
   logic fnn_ff, fnn_in;
   logic has_bytes_ff, has_bytes_in;
   logic last_comma_ff, last_comma_in;
   logic halted_ff, halted_in;

   logic                is_digit, is_other_space, is_quote, is_space, row_end;
   csvrs_pkg::mask_type field_bit;
   cnt_type             count, fc;

   assign is_digit       = char_byte inside {[csvrs_pkg::CH_ZERO:csvrs_pkg::CH_NINE]};
   assign is_other_space = char_byte inside {[csvrs_pkg::CH_TAB:csvrs_pkg::CH_CR]};
   assign is_quote       = (char_byte == csvrs_pkg::CH_QUOTE);
   assign is_space       = (char_byte == csvrs_pkg::CH_SPACE);
   assign row_end        = end_of_stream || (char_byte == csvrs_pkg::CH_LF);

   // String bit of the field being closed; columns past the mask width fall off
   assign field_bit = fnn_ff ? (csvrs_pkg::mask_type'(1) << idx_ff) : '0;

   assign count = cnt_type'(idx_ff + cnt_type'(1) + cnt_type'(last_comma_ff && in_q_ff));
   assign fc    = (count > cnt_type'(MAX_COLUMNS)) ? cnt_type'(MAX_COLUMNS) : count;

   always_comb begin
      col_mask_in   = col_mask_ff;
      row_mask_in   = row_mask_ff;
      rows_in       = rows_ff;
      idx_in        = idx_ff;
      in_q_in       = in_q_ff;
      started_in    = started_ff;
      opened_in     = opened_ff;
      hquote_in     = hquote_ff;
      hspace_in     = hspace_ff;
      period_in     = period_ff;
      fnn_in        = fnn_ff;
      has_bytes_in  = has_bytes_ff;
      last_comma_in = last_comma_ff;
      halted_in     = halted_ff;
      stat.res_valid = 1'b0;
      stat.halted    = halted_ff;
      res.status             = csvrs_pkg::ST_ACCEPT;
      res.field_count        = '0;
      res.column_string_mask = col_mask_ff;
      res.rows_accepted      = rows_ff;

      if (step && !halted_ff) begin
         if (!row_end) begin
            has_bytes_in  = 1'b1;
            last_comma_in = (char_byte == csvrs_pkg::CH_COMMA);
            if (is_quote) begin
               in_q_in = !in_q_ff;
            end
            if ((char_byte == csvrs_pkg::CH_COMMA) && !in_q_ff) begin
               // field separator
               row_mask_in = row_mask_ff | field_bit;
               started_in  = 1'b0;
               opened_in   = 1'b0;
               hquote_in   = 1'b0;
               hspace_in   = 1'b0;
               period_in   = 1'b0;
               fnn_in      = 1'b0;
               if (idx_ff < cnt_type'(MAX_COLUMNS)) begin
                  idx_in = cnt_type'(idx_ff + cnt_type'(1));
               end
            end else begin
               // a held closing quote turned out to be inner text
               if (hquote_ff) begin
                  hquote_in = 1'b0;
                  hspace_in = 1'b0;
                  fnn_in    = 1'b1;
               end
               if (!started_ff && (is_quote || is_space)) begin
                  if (is_quote) begin
                     opened_in = 1'b1;
                  end
               end else if (is_quote && opened_ff) begin
                  hquote_in = 1'b1;
               end else if (is_space) begin
                  hspace_in = 1'b1;
               end else if (is_other_space) begin
                  // dropped
               end else if (started_ff) begin
                  if (hspace_in) begin
                     fnn_in = 1'b1;
                  end
                  hspace_in = 1'b0;
                  if (is_digit) begin
                     // stays numeric
                  end else if ((char_byte == csvrs_pkg::CH_PERIOD) && !period_ff) begin
                     period_in = 1'b1;
                  end else begin
                     fnn_in = 1'b1;
                  end
               end else begin
                  started_in = 1'b1;
                  if (is_digit || (char_byte == csvrs_pkg::CH_MINUS)) begin
                     // numeric start
                  end else if (char_byte == csvrs_pkg::CH_PERIOD) begin
                     period_in = 1'b1;
                  end else begin
                     fnn_in = 1'b1;
                  end
               end
            end
         end else if (!has_bytes_ff) begin
            // empty line: end of data
            stat.res_valid = 1'b1;
            halted_in      = 1'b1;
            res.status     = csvrs_pkg::ST_END;
         end else begin
            stat.res_valid  = 1'b1;
            res.field_count = csvrs_pkg::col_type'(fc);
            if (count > cnt_type'(MAX_COLUMNS)) begin
               res.status = csvrs_pkg::ST_OVERFLOW;
               halted_in  = 1'b1;
            end else if (cmp_type'(count) != cmp_type'(expected_columns)) begin
               res.status = csvrs_pkg::ST_MISMATCH;
               halted_in  = 1'b1;
            end else begin
               col_mask_in = col_mask_ff | row_mask_ff | field_bit;
               if (rows_ff != '1) begin
                  rows_in = csvrs_pkg::rows_type'(rows_ff + csvrs_pkg::rows_type'(1));
               end
            end
            res.column_string_mask = col_mask_in;
            res.rows_accepted      = rows_in;
            row_mask_in   = '0;
            idx_in        = '0;
            in_q_in       = 1'b0;
            started_in    = 1'b0;
            opened_in     = 1'b0;
            hquote_in     = 1'b0;
            hspace_in     = 1'b0;
            period_in     = 1'b0;
            fnn_in        = 1'b0;
            has_bytes_in  = 1'b0;
            last_comma_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_mask_ff   <= '0;
         row_mask_ff   <= '0;
         rows_ff       <= '0;
         idx_ff        <= '0;
         in_q_ff       <= 1'b0;
         started_ff    <= 1'b0;
         opened_ff     <= 1'b0;
         hquote_ff     <= 1'b0;
         hspace_ff     <= 1'b0;
         period_ff     <= 1'b0;
         fnn_ff        <= 1'b0;
         has_bytes_ff  <= 1'b0;
         last_comma_ff <= 1'b0;
         halted_ff     <= 1'b0;
      end else begin
         col_mask_ff   <= col_mask_in;
         row_mask_ff   <= row_mask_in;
         rows_ff       <= rows_in;
         idx_ff        <= idx_in;
         in_q_ff       <= in_q_in;
         started_ff    <= started_in;
         opened_ff     <= opened_in;
         hquote_ff     <= hquote_in;
         hspace_ff     <= hspace_in;
         period_ff     <= period_in;
         fnn_ff        <= fnn_in;
         has_bytes_ff  <= has_bytes_in;
         last_comma_ff <= last_comma_in;
         halted_ff     <= halted_in;
      end
   end

endmodule

[rtl/csv_row_split_type_infer.sv]
// ----------------------------------------------------------------------------
// csv_row_split_type_infer
// CSV field tokenizer with per-column numeric/string type inference.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ stream carries one CSV text byte per transaction in req_tdata;
//    req_tlast marks end of stream (byte ignored, closes any pending row).
//  - rsp_ stream returns one transaction per closed row (newline or end of
//    stream): status, field count, accumulated column string mask, row count.
//    Bytes that do not close a row produce no transaction.
//  - csr_ port writes expected_columns (resets to 1); write it only while idle.
//  - Result path: the closing byte's transaction fills the input register,
//    then tokenizer logic writes the result register that drives rsp_tvalid.
//  - Throughput: one byte per cycle while the receiver keeps up; set by the
//    single tokenizer step between input and result registers.
//  - Reset clears the column mask, row counter, tokenizer state and halt flag.
//  - After status 1, 2 or 3 the block halts: bytes are still taken, dropped.
//  - If the receiver stalls with a result pending, the input register keeps
//    its byte and req_tready drops once it is full.
// ----------------------------------------------------------------------------
module csv_row_split_type_infer #(
   parameter int MAX_COLUMNS = csvrs_pkg::MAX_COLUMNS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // byte input
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [csvrs_pkg::BYTE_W-1:0] req_tdata,  // [7:0] char_byte
   input  logic                        req_tlast,  // end_of_stream
   // row result
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [1:0] status, [7:2] field_count, [39:8] column_string_mask,
   // [55:40] rows_accepted
   output logic [csvrs_pkg::RSP_W-1:0]  rsp_tdata,
   // configuration
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [csvrs_pkg::COL_W-1:0]  csr_data    // expected_columns
);

   // input register
   logic                s1_valid_ff, s1_valid_in;
   csvrs_pkg::byte_type s1_byte_ff;
   logic                s1_eos_ff;
   logic                s1_adv;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   csvrs_pkg::rsp_type  rsp_data_ff;
   logic                out_free;

   csvrs_pkg::col_type  exp_cols_ff;

   csvrs_pkg::core_stat_type core_stat;
   csvrs_pkg::rsp_type       core_res;

   // The result register can take a new row when empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   assign s1_valid_in  = (req_tvalid && req_tready) || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = core_stat.res_valid || (rsp_valid_ff && !rsp_tready);

   csvrs_core #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (s1_adv),
      .char_byte        (s1_byte_ff),
      .end_of_stream    (s1_eos_ff),
      .expected_columns (exp_cols_ff),
      .stat             (core_stat),
      .res              (core_res)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         exp_cols_ff  <= csvrs_pkg::col_type'(1);
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            exp_cols_ff <= csr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_eos_ff  <= req_tlast;
      end
      if (core_stat.res_valid) begin
         rsp_data_ff <= core_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.rows_accepted,
                        rsp_data_ff.column_string_mask,
                        rsp_data_ff.field_count,
                        rsp_data_ff.status};

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // A halted tokenizer never closes another row.
   a_no_result_when_halted : assert property (@(posedge clock) disable iff (reset)
      core_stat.halted |-> !core_stat.res_valid)
      else $error("result produced while halted");

   // A row only closes when the result register has room for it.
   a_result_has_room : assert property (@(posedge clock) disable iff (reset)
      core_stat.res_valid |-> out_free)
      else $error("row closed with result register full");

   // A buffered byte that could not advance is still held next cycle.
   a_byte_not_lost : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("buffered byte lost under stall");

   // End of data always reports zero fields.
   a_end_zero_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == csvrs_pkg::ST_END)
         |-> (rsp_data_ff.field_count == '0))
      else $error("end-of-data result with nonzero field count");

endmodule

[dv/csv_row_split_type_infer_tb.sv]
// ----------------------------------------------------------------------------
// csv_row_split_type_infer_tb
// Self-checking bench for the CSV row splitter with per-column type inference.
// A directed table of rows goes first, then random rows built to match the
// configured column count, then one row that halts the block, then dropped
// bytes. A bit-level tokenizer model predicts every row result.
// ----------------------------------------------------------------------------
module csv_row_split_type_infer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXC         = csvrs_pkg::MAX_COLUMNS_DEF;
   localparam int RANDOM_ITEMS = 1600;
   localparam int HOLD_CYCLES  = 300;
   localparam int N_DIR        = 17;
   // whitespace the trim rules drop, not in the package
   localparam csvrs_pkg::byte_type CH_VT = 8'h0b;
   localparam csvrs_pkg::byte_type CH_FF = 8'h0c;

   // ---------------------------------------------------------------------
   // DUT inputs, all known from time zero
   // ---------------------------------------------------------------------
   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [csvrs_pkg::BYTE_W-1:0]  req_tdata  = '0;   // [7:0] char_byte
   logic                          req_tlast  = 1'b0; // end_of_stream
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   // [1:0] status, [7:2] field_count, [39:8] column_string_mask,
   // [55:40] rows_accepted
   logic [csvrs_pkg::RSP_W-1:0]   rsp_tdata;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [csvrs_pkg::COL_W-1:0]   csr_data   = '0;   // expected_columns

   csv_row_split_type_infer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Row result as seen on rsp_tdata
   // ---------------------------------------------------------------------
   typedef struct {
      csvrs_pkg::status_type status;
      csvrs_pkg::col_type    field_count;
      csvrs_pkg::mask_type   mask;
      csvrs_pkg::rows_type   rows;
   } row_result_type;

   row_result_type rows_due[$];   // predicted row results, oldest first
   int             mismatches = 0;

   // Directed rows. Text is sent byte by byte, then a newline (or an
   // end-of-stream transaction when at_eos is set). '~' stands for byte 0x00
   // and '^' for 0xFF. Rows with typed set carry their status/count by hand.
   typedef struct {
      string text;
      int    cols;
      bit    at_eos;
      bit    typed;
      int    fc;
   } dir_row_type;

   dir_row_type directed_rows [N_DIR] = '{
      '{"7",            1, 1'b0, 1'b1, 1},   // first row after reset
      '{"abc",          1, 1'b0, 1'b1, 1},   // plain string
      '{"-",            1, 1'b0, 1'b0, 0},   // lone minus is numeric
      '{"\"-3.5\"",     1, 1'b0, 1'b0, 0},   // quoted number, quotes trimmed
      '{"  42",         1, 1'b0, 1'b0, 0},   // leading spaces skipped
      '{"4 2",          1, 1'b0, 1'b0, 0},   // inner space -> string
      '{"\t1\015",      1, 1'b0, 1'b0, 0},   // tab/CR dropped
      '{"1.2.3",        1, 1'b0, 1'b0, 0},   // second period -> string
      '{".5",           1, 1'b1, 1'b0, 0},   // closed by end of stream
      '{"\"ab",         1, 1'b0, 1'b0, 0},   // newline inside quotes
      '{"~",            1, 1'b0, 1'b0, 0},   // zero byte
      '{"^",            1, 1'b0, 1'b0, 0},   // high byte
      '{"1,",           2, 1'b0, 1'b1, 2},   // trailing comma adds a field
      '{"\"x,",         2, 1'b0, 1'b1, 2},   // trailing comma inside quotes
      '{"\"a,b\",-1",   2, 1'b0, 1'b0, 0},   // quoted comma
      '{"12 , \"7\"",   2, 1'b1, 1'b0, 0},   // trailing space, quoted number
      '{"0,1,2,3,4,5,6,7,8,9,0,1,2,3,4,5,6,7,8,9,0,1,2,3,4,5,6,7,8,9,0,z",
                        32, 1'b0, 1'b1, 32}  // widest row, top column string
   };

   // ---------------------------------------------------------------------
   // Tokenizer model state (reset values)
   // ---------------------------------------------------------------------
   csvrs_pkg::col_type  cfg_columns   = 6'd1;
   csvrs_pkg::mask_type col_mask_acc  = '0;
   csvrs_pkg::mask_type row_bits      = '0;
   int                  comma_count   = 0;
   bit                  quoted        = 1'b0;
   bit                  text_started  = 1'b0;
   bit                  lead_quote    = 1'b0;
   bit                  quote_held    = 1'b0;
   bit                  space_held    = 1'b0;
   bit                  dot_seen      = 1'b0;
   bit                  not_numeric   = 1'b0;
   bit                  row_open      = 1'b0;
   bit                  prev_comma    = 1'b0;
   bit                  stopped       = 1'b0;
   csvrs_pkg::rows_type accepted_rows = '0;

   // Hand-typed override for the next predicted result
   bit                    typed_armed  = 1'b0;
   csvrs_pkg::status_type typed_status = csvrs_pkg::ST_ACCEPT;
   int                    typed_count  = 0;

   // Traffic shaping shared by both sides
   bit calm     = 1'b0;   // no idling at all in this stretch
   bit hold_req = 1'b0;   // receiver: stall request, cleared when the stall ends
   int bytes_sent = 0;

   function automatic bit is_digit(csvrs_pkg::byte_type c);
      return c >= csvrs_pkg::CH_ZERO && c <= csvrs_pkg::CH_NINE;
   endfunction

   function automatic bit is_blank(csvrs_pkg::byte_type c);
      return c == csvrs_pkg::CH_TAB || c == csvrs_pkg::CH_LF || c == CH_VT ||
             c == CH_FF || c == csvrs_pkg::CH_CR;
   endfunction

   // a character that survives trimming joins the field text
   function automatic void absorb_char(csvrs_pkg::byte_type c);
      if (text_started) begin
         if (space_held) not_numeric = 1'b1;
         space_held = 1'b0;
         if (!is_digit(c)) begin
            if (c == csvrs_pkg::CH_PERIOD && !dot_seen) dot_seen = 1'b1;
            else not_numeric = 1'b1;
         end
      end else begin
         text_started = 1'b1;
         if (c == csvrs_pkg::CH_PERIOD) dot_seen = 1'b1;
         else if (c != csvrs_pkg::CH_MINUS && !is_digit(c)) not_numeric = 1'b1;
      end
   endfunction

   function automatic void trim_byte(csvrs_pkg::byte_type c);
      // a held quote turned out not to be the last one
      if (quote_held) begin
         quote_held = 1'b0;
         absorb_char(csvrs_pkg::CH_QUOTE);
      end
      if (!text_started && (c == csvrs_pkg::CH_QUOTE || c == csvrs_pkg::CH_SPACE)) begin
         if (c == csvrs_pkg::CH_QUOTE) lead_quote = 1'b1;
      end else if (c == csvrs_pkg::CH_QUOTE && lead_quote) begin
         quote_held = 1'b1;
      end else if (c == csvrs_pkg::CH_SPACE) begin
         space_held = 1'b1;
      end else if (!is_blank(c)) begin
         absorb_char(c);
      end
   endfunction

   function automatic void close_field();
      if (not_numeric && comma_count < 32)
         row_bits |= csvrs_pkg::mask_type'(1) << comma_count;
      text_started = 1'b0;
      lead_quote   = 1'b0;
      quote_held   = 1'b0;
      space_held   = 1'b0;
      dot_seen     = 1'b0;
      not_numeric  = 1'b0;
   endfunction

   function automatic void start_row();
      close_field();
      row_bits    = '0;
      comma_count = 0;
      quoted      = 1'b0;
      row_open    = 1'b0;
      prev_comma  = 1'b0;
   endfunction

   // One byte transaction in; returns 1 with the row result when a row closes.
   function automatic bit tokenize(csvrs_pkg::byte_type c, logic eos,
                                   output row_result_type r);
      int cnt;
      r = '{csvrs_pkg::ST_ACCEPT, '0, '0, '0};
      if (stopped) return 1'b0;
      if (!eos && c != csvrs_pkg::CH_LF) begin
         row_open = 1'b1;
         if (c == csvrs_pkg::CH_QUOTE) quoted = !quoted;
         if (c == csvrs_pkg::CH_COMMA && !quoted) begin
            close_field();
            if (comma_count < MAXC) comma_count++;
         end else begin
            trim_byte(c);
         end
         prev_comma = (c == csvrs_pkg::CH_COMMA);
         return 1'b0;
      end
      // empty line: end of data, block halts
      if (!row_open) begin
         stopped = 1'b1;
         r = '{csvrs_pkg::ST_END, '0, col_mask_acc, accepted_rows};
         return 1'b1;
      end
      close_field();
      cnt = comma_count + 1 + ((prev_comma && quoted) ? 1 : 0);
      if (cnt > MAXC) begin
         r.status = csvrs_pkg::ST_OVERFLOW;
         stopped  = 1'b1;
      end else if (cnt != int'(cfg_columns)) begin
         r.status = csvrs_pkg::ST_MISMATCH;
         stopped  = 1'b1;
      end else begin
         r.status = csvrs_pkg::ST_ACCEPT;
         col_mask_acc |= row_bits;
         if (accepted_rows != 16'hffff) accepted_rows++;
      end
      r.field_count = csvrs_pkg::col_type'((cnt > MAXC) ? MAXC : cnt);
      r.mask        = col_mask_acc;
      r.rows        = accepted_rows;
      start_row();
      return 1'b1;
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned seen);
      if (want != seen) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, seen);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard: predict on every accepted byte, check every accepted result.
   // Both sides are sampled at the rising edge, before this step's updates.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      row_result_type want, got, seen;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status      = csvrs_pkg::status_type'(rsp_tdata[1:0]);
            seen.field_count = rsp_tdata[7:2];
            seen.mask        = rsp_tdata[39:8];
            seen.rows        = rsp_tdata[55:40];
            if (rows_due.size() == 0) begin
               $error("row result with nothing expected: status %0d count %0d",
                      seen.status, seen.field_count);
               mismatches++;
            end else begin
               want = rows_due.pop_front();
               check_field("status", want.status, seen.status);
               check_field("field_count", want.field_count, seen.field_count);
               check_field("column_string_mask", want.mask, seen.mask);
               check_field("rows_accepted", want.rows, seen.rows);
            end
         end
         if (req_tvalid && req_tready) begin
            if (tokenize(req_tdata, req_tlast, got)) begin
               // hand-typed status/count replaces the model's for marked rows
               if (typed_armed) begin
                  got.status      = typed_status;
                  got.field_count = csvrs_pkg::col_type'(typed_count);
                  typed_armed     = 1'b0;
               end
               rows_due.push_back(got);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Gap lengths: mostly none or short, a few long
   // ---------------------------------------------------------------------
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: random backpressure; a long hold on request, counted here
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int n;
      wait (!reset);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            n = idle_len();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender helpers
   // ---------------------------------------------------------------------
   // one byte transaction; tvalid stays high into the next call when no gap
   task automatic send_byte(csvrs_pkg::byte_type c, logic eos);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Row text, then its terminator. The hand-typed result is armed only once
   // the text is in, so it can never attach to the previous row.
   task automatic send_row(csvrs_pkg::byte_type q[$], bit at_eos, bit typed,
                           csvrs_pkg::status_type st, int fc);
      foreach (q[i]) send_byte(q[i], 1'b0);
      if (typed) begin
         typed_status = st;
         typed_count  = fc;
         typed_armed  = 1'b1;
      end
      if (at_eos) send_byte(csvrs_pkg::byte_type'($urandom_range(0, 255)), 1'b1);
      else send_byte(csvrs_pkg::CH_LF, 1'b0);
   endtask

   // stop offering, let the last transaction reach the scoreboard, wait for
   // every result, then cover the pipe latency
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rows_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_columns(csvrs_pkg::col_type n);
      csr_valid <= 1'b1;
      csr_data  <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      cfg_columns  = n;
   endtask

   function automatic void push_digits(ref csvrs_pkg::byte_type q[$], input int n);
      for (int i = 0; i < n; i++)
         q.push_back(csvrs_pkg::byte_type'(csvrs_pkg::CH_ZERO + $urandom_range(0, 9)));
   endfunction

   // field count exactly as the block counts it
   function automatic int count_fields(csvrs_pkg::byte_type q[$]);
      int  commas;
      bit  qt, last;
      commas = 0;
      qt     = 1'b0;
      last   = 1'b0;
      foreach (q[i]) begin
         if (q[i] == csvrs_pkg::CH_QUOTE) qt = !qt;
         if (q[i] == csvrs_pkg::CH_COMMA && !qt && commas < MAXC) commas++;
         last = (q[i] == csvrs_pkg::CH_COMMA);
      end
      return commas + 1 + ((last && qt) ? 1 : 0);
   endfunction

   // one field of random flavor: numbers, strings, quoting, whitespace, noise
   function automatic void add_field(ref csvrs_pkg::byte_type q[$]);
      int n;
      case ($urandom_range(0, 11))
         0: begin
            if ($urandom_range(0, 1)) q.push_back(csvrs_pkg::CH_MINUS);
            push_digits(q, $urandom_range(1, 5));
         end
         1: begin
            if ($urandom_range(0, 2) == 0) q.push_back(csvrs_pkg::CH_MINUS);
            push_digits(q, $urandom_range(0, 3));
            q.push_back(csvrs_pkg::CH_PERIOD);
            push_digits(q, $urandom_range(0, 3));
         end
         2: begin
            repeat ($urandom_range(0, 2)) q.push_back(csvrs_pkg::CH_SPACE);
            q.push_back(csvrs_pkg::CH_QUOTE);
            push_digits(q, $urandom_range(0, 4));
            q.push_back(csvrs_pkg::CH_QUOTE);
         end
         3: repeat ($urandom_range(1, 6))
               q.push_back(csvrs_pkg::byte_type'(8'h61 + $urandom_range(0, 25)));
         4: begin
            push_digits(q, $urandom_range(1, 3));
            q.push_back(csvrs_pkg::CH_SPACE);
            push_digits(q, $urandom_range(1, 3));
         end
         5: repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 4))
               0: q.push_back(csvrs_pkg::CH_TAB);
               1: q.push_back(CH_VT);
               2: q.push_back(CH_FF);
               3: q.push_back(csvrs_pkg::CH_CR);
               default: push_digits(q, 1);
            endcase
         end
         6: ;  // empty field
         7: repeat ($urandom_range(1, 4)) begin
            n = $urandom_range(0, 255);
            if (n == csvrs_pkg::CH_LF) n = csvrs_pkg::CH_CR;
            q.push_back(csvrs_pkg::byte_type'(n));
         end
         8: begin
            push_digits(q, 1);
            q.push_back(csvrs_pkg::CH_PERIOD);
            push_digits(q, $urandom_range(0, 2));
            q.push_back(csvrs_pkg::CH_PERIOD);
            push_digits(q, 1);
         end
         9: begin
            q.push_back(csvrs_pkg::CH_SPACE);
            push_digits(q, $urandom_range(1, 3));
            repeat ($urandom_range(1, 2)) q.push_back(csvrs_pkg::CH_SPACE);
         end
         10: begin
            q.push_back(csvrs_pkg::CH_QUOTE);
            push_digits(q, 1);
            q.push_back(csvrs_pkg::CH_COMMA);
            push_digits(q, 1);
            q.push_back(csvrs_pkg::CH_QUOTE);
         end
         default: begin
            // unbalanced quote, mostly gets the row rebuilt
            q.push_back(csvrs_pkg::CH_QUOTE);
            push_digits(q, $urandom_range(1, 3));
         end
      endcase
   endfunction

   // A row that the block will accept at the given width. Random rows whose
   // quoting swallows or adds a comma are rebuilt; plain zeros as a last resort.
   function automatic void build_row(int cols, ref csvrs_pkg::byte_type q[$]);
      for (int t = 0; t < 8; t++) begin
         q.delete();
         for (int i = 0; i < cols; i++) begin
            if (i > 0) q.push_back(csvrs_pkg::CH_COMMA);
            add_field(q);
         end
         if (q.size() == 0) q.push_back(csvrs_pkg::CH_SPACE);   // keep the line nonempty
         if (count_fields(q) == cols) return;
      end
      q.delete();
      for (int i = 0; i < cols; i++) begin
         if (i > 0) q.push_back(csvrs_pkg::CH_COMMA);
         q.push_back(csvrs_pkg::CH_ZERO);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      csvrs_pkg::byte_type row[$];
      int                  phase, phase_end, random_start, cols, bad;
      bit                  paused;
      csvrs_pkg::byte_type b;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; the width register starts at its reset value of 1
      foreach (directed_rows[i]) begin
         if (directed_rows[i].cols != int'(cfg_columns)) begin
            settle();
            write_columns(csvrs_pkg::col_type'(directed_rows[i].cols));
         end
         row.delete();
         for (int j = 0; j < directed_rows[i].text.len(); j++) begin
            case (directed_rows[i].text[j])
               "~":     b = 8'h00;
               "^":     b = 8'hff;
               default: b = csvrs_pkg::byte_type'(directed_rows[i].text[j]);
            endcase
            row.push_back(b);
         end
         send_row(row, directed_rows[i].at_eos, directed_rows[i].typed,
                  csvrs_pkg::ST_ACCEPT, directed_rows[i].fc);
      end

      // random phases, each at its own width: 1 and 32 first, then mixed,
      // mostly narrow so that long rows stay rare
      phase        = 0;
      paused       = 1'b0;
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_ITEMS) begin
         if (phase == 0) cols = 1;
         else if (phase == 1) cols = MAXC;
         else if ($urandom_range(0, 9) < 5) cols = $urandom_range(1, 4);
         else if ($urandom_range(0, 2) < 2) cols = $urandom_range(5, 16);
         else cols = $urandom_range(17, MAXC);
         settle();
         write_columns(csvrs_pkg::col_type'(cols));
         calm = ($urandom_range(0, 3) == 0);
         // long receiver stall while the sender keeps pushing
         if (phase == 2) begin
            calm     = 1'b1;
            hold_req = 1'b1;
         end
         phase_end = bytes_sent + $urandom_range(100, 250);
         while (bytes_sent < phase_end) begin
            build_row(cols, row);
            send_row(row, $urandom_range(0, 6) == 0, 1'b0, csvrs_pkg::ST_ACCEPT, 0);
            // sender pauses mid-phase until every result is back
            if (phase == 3 && !paused) begin
               paused = 1'b1;
               settle();
            end
         end
         phase++;
      end
      calm = 1'b0;

      // one row that ends the run of the block; it halts until reset
      settle();
      row.delete();
      case ($urandom_range(0, 5))
         0: send_row(row, 1'b0, 1'b1, csvrs_pkg::ST_END, 0);   // empty line
         1: send_row(row, 1'b1, 1'b1, csvrs_pkg::ST_END, 0);   // end of stream, no bytes
         2: begin                                              // column count mismatch
            bad = (int'(cfg_columns) < MAXC) ? int'(cfg_columns) + 1 : MAXC - 1;
            build_row(bad, row);
            send_row(row, 1'b0, 1'b1, csvrs_pkg::ST_MISMATCH, bad);
         end
         3: begin                                              // too many fields
            for (int i = 0; i < 40; i++) begin
               if (i > 0) row.push_back(csvrs_pkg::CH_COMMA);
               push_digits(row, 1);
            end
            send_row(row, 1'b0, 1'b1, csvrs_pkg::ST_OVERFLOW, MAXC);
         end
         4: begin                                              // width register of 0
            write_columns('0);
            push_digits(row, 1);
            send_row(row, 1'b0, 1'b1, csvrs_pkg::ST_MISMATCH, 1);
         end
         default: begin                                        // width above the maximum
            write_columns('1);
            push_digits(row, 1);
            row.push_back(csvrs_pkg::CH_COMMA);
            push_digits(row, 1);
            send_row(row, 1'b0, 1'b1, csvrs_pkg::ST_MISMATCH, 2);
         end
      endcase

      // halted: bytes, newlines and end of stream are taken and dropped
      for (int i = 0; i < 24; i++) begin
         b = csvrs_pkg::byte_type'($urandom_range(0, 255));
         if (i % 5 == 0) b = csvrs_pkg::CH_LF;
         send_byte(b, i == 20);
      end
      req_tvalid <= 1'b0;

      for (int k = 0; k < 5000 && rows_due.size() != 0; k++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (rows_due.size() != 0) begin
         $error("%0d row results never arrived", rows_due.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Watchdog: far beyond the slowest legal run
   // ---------------------------------------------------------------------
   initial begin : watchdog
      #20_000_000ns;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[filelist.f]
rtl/csvrs_pkg.sv
rtl/csvrs_core.sv
rtl/csv_row_split_type_infer.sv
dv/csv_row_split_type_infer_tb.sv
